// ----- rtl/core/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared sizes, constants and the command and status bundles that pass
// between the LFU table controller and its datapath.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int CAPACITY    = 16;
  localparam int COUNT_WIDTH = 16;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W = IDX_W;
  localparam int OCC_W  = $clog2(CAPACITY + 1);
  localparam int EFF_W  = (CFG_W > OCC_W) ? CFG_W : OCC_W;

  localparam logic [CFG_W-1:0]       CFG_RESET = CFG_W'(16);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [DATA_W-1:0]      MISS_DATA = '1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load_in;      // latch request beat, start lookup scan
    logic scan_lookup;  // advance lookup scan one entry
    logic vscan_init;   // restart scan for victim search
    logic scan_victim;  // advance victim scan one entry
    logic do_touch;     // promote hit entry, write value on put
    logic do_evict;     // drop selected victim
    logic do_insert;    // place new key in lowest free slot
    logic load_out;     // capture response into output register
  } lfu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
    logic found;
    logic is_put;
    logic cap_zero;
    logic need_evict;
  } lfu_status_t;

endpackage

// ----- rtl/core/lfu_req_if.sv -----
// ----------------------------------------------------------------------------
// lfu_req_if
// Request channel: valid/ready handshake with opcode, key and write value.
// ----------------------------------------------------------------------------
interface lfu_req_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic signed [31:0]  lookup_key;
  logic signed [31:0]  write_value;

  modport source (output valid, output opcode, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input opcode, input lookup_key, input write_value,
                  output ready);
endinterface

// ----- rtl/core/lfu_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lfu_rsp_if
// Response channel: valid/ready handshake with hit flag and read value.
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [31:0]  read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ----- rtl/core/lfu_cache_table.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key-value table with least-frequently-used replacement and a recency
// tiebreak among entries of equal use count.
// ----------------------------------------------------------------------------
// The table takes one request beat at a time and answers each with exactly
// one response beat. A get miss or a put while the capacity register is
// zero passes from the lookup scan through the decision to the output
// register; a get hit and a put hit add a touch step, a put that inserts
// without eviction adds an insert step, and a put that must evict adds a
// victim scan and an eviction step for every victim removed (more than one
// only when the capacity register was lowered below the current fill). The
// time taken is set by the sequential scan that reads one entry per cycle,
// once to find the key and once per eviction to find the victim. A finished
// response waits in the output register, so a new request is accepted while
// the previous response is still pending; only the final hand-off of that
// next request waits for the output register to drain. Write the capacity
// register only while the table is idle. All entries read as empty after
// reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lfu_cache_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CFG_W-1:0] cfg_wdata_i,
  lfu_req_if.sink                   req_i,
  lfu_rsp_if.source                 rsp_o
);
  import lfu_pkg::*;

  lfu_cmd_t    cmd;
  lfu_status_t status;
  logic        in_ready;
  logic        out_valid;
  logic        hit;
  logic [DATA_W-1:0] read_value;

  // Sequencer: owns the handshakes and steps the datapath.
  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: entries, scan state, capacity register and output register.
  lfu_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (req_i.opcode),
    .lookup_key_i  (req_i.lookup_key),
    .write_value_i (req_i.write_value),
    .cmd_i         (cmd),
    .status_o      (status),
    .hit_o         (hit),
    .read_value_o  (read_value)
  );

  assign req_i.ready      = in_ready;
  assign rsp_o.valid      = out_valid;
  assign rsp_o.hit        = hit;
  assign rsp_o.read_value = read_value;

endmodule

// ----- rtl/core/lfu_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer for the LFU table: lookup scan, decision, victim scans with
// evictions, then touch or insert where the request needs one, and hand-off to the output register.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lfu_pkg::lfu_status_t status_i,
  output lfu_pkg::lfu_cmd_t    cmd_o
);
  import lfu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_TOUCH,
    ST_VSCAN,
    ST_EVICT,
    ST_INSERT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.scan_lookup = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!status_i.is_put) begin
          state_d = status_i.found ? ST_TOUCH : ST_FINISH;
        end else if (status_i.cap_zero) begin
          state_d = ST_FINISH;
        end else if (status_i.found) begin
          state_d = ST_TOUCH;
        end else if (status_i.need_evict) begin
          cmd_o.vscan_init = 1'b1;
          state_d          = ST_VSCAN;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_TOUCH: begin
        cmd_o.do_touch = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_VSCAN: begin
        cmd_o.scan_victim = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        cmd_o.do_evict = 1'b1;
        state_d        = ST_DECIDE;
      end
      ST_INSERT: begin
        cmd_o.do_insert = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/lfu_dp.sv -----
// ----------------------------------------------------------------------------
// lfu_dp
// Entry storage, scan registers, capacity register and output register of
// the LFU table. Entries are read one at a time at the scan index.
// ----------------------------------------------------------------------------
module lfu_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      opcode_i,
  input  logic [lfu_pkg::KEY_W-1:0] lookup_key_i,
  input  logic [lfu_pkg::DATA_W-1:0] write_value_i,
  input  lfu_pkg::lfu_cmd_t         cmd_i,
  output lfu_pkg::lfu_status_t      status_o,
  output logic                      hit_o,
  output logic [lfu_pkg::DATA_W-1:0] read_value_o
);
  import lfu_pkg::*;

  // Capacity register
  logic [CFG_W-1:0] cap_q;

  // Entry state
  logic [CAPACITY-1:0]                  valid_q, valid_d;
  logic [CAPACITY-1:0][KEY_W-1:0]       key_q, key_d;
  logic [CAPACITY-1:0][DATA_W-1:0]      val_q, val_d;
  logic [CAPACITY-1:0][COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [CAPACITY-1:0][RANK_W-1:0]      rank_q, rank_d;
  logic [OCC_W-1:0]                     occ_q, occ_d;

  // Request
  logic              is_put_q;
  logic [KEY_W-1:0]  req_key_q;
  logic [DATA_W-1:0] req_val_q;

  // Scan
  logic [IDX_W-1:0]       scan_idx_q;
  logic                   found_q;
  logic [IDX_W-1:0]       slot_q;
  logic [COUNT_WIDTH-1:0] slot_cnt_q;
  logic [RANK_W-1:0]      slot_rank_q;
  logic [DATA_W-1:0]      slot_val_q;
  logic                   vfound_q;
  logic [IDX_W-1:0]       victim_q;
  logic [COUNT_WIDTH-1:0] vcnt_q;
  logic [RANK_W-1:0]      vrank_q;

  // Output register
  logic              hit_q;
  logic [DATA_W-1:0] rdata_q;

  logic                   cur_valid;
  logic [KEY_W-1:0]       cur_key;
  logic [DATA_W-1:0]      cur_val;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [RANK_W-1:0]      cur_rank;
  logic                   cur_match;
  logic                   cur_better;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic [EFF_W-1:0]       eff_cap;

  assign cur_valid = valid_q[scan_idx_q];
  assign cur_key   = key_q[scan_idx_q];
  assign cur_val   = val_q[scan_idx_q];
  assign cur_cnt   = cnt_q[scan_idx_q];
  assign cur_rank  = rank_q[scan_idx_q];
  assign cur_match = cur_valid && (cur_key == req_key_q) && !found_q;
  assign cur_better = cur_valid && (!vfound_q || (cur_cnt < vcnt_q) ||
                      ((cur_cnt == vcnt_q) && (cur_rank > vrank_q)));

  assign eff_cap = (EFF_W'(cap_q) < EFF_W'(CAPACITY)) ? EFF_W'(cap_q) : EFF_W'(CAPACITY);

  assign status_o.scan_last  = (scan_idx_q == IDX_W'(CAPACITY - 1));
  assign status_o.found      = found_q;
  assign status_o.is_put     = is_put_q;
  assign status_o.cap_zero   = (cap_q == '0);
  assign status_o.need_evict = (EFF_W'(occ_q) >= eff_cap) && (occ_q != '0);

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Entry updates
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    rank_d  = rank_q;
    occ_d   = occ_q;

    if (cmd_i.do_touch) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid_q[i] && (IDX_W'(i) != slot_q) && (rank_q[i] < slot_rank_q)) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
      rank_d[slot_q] = '0;
      if (slot_cnt_q != COUNT_MAX) begin
        cnt_d[slot_q] = slot_cnt_q + 1'b1;
      end
      if (is_put_q) begin
        val_d[slot_q] = req_val_q;
      end
    end

    if (cmd_i.do_evict && vfound_q) begin
      valid_d[victim_q] = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid_q[i] && (rank_q[i] > vrank_q)) begin
          rank_d[i] = rank_q[i] - 1'b1;
        end
      end
      occ_d = occ_q - 1'b1;
    end

    if (cmd_i.do_insert) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
      if (free_found) begin
        valid_d[free_idx] = 1'b1;
        key_d[free_idx]   = req_key_q;
        val_d[free_idx]   = req_val_q;
        cnt_d[free_idx]   = COUNT_WIDTH'(1);
        rank_d[free_idx]  = '0;
        occ_d             = occ_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CFG_RESET;
      valid_q    <= '0;
      occ_q      <= '0;
      scan_idx_q <= '0;
      found_q    <= 1'b0;
      vfound_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      valid_q <= valid_d;
      occ_q   <= occ_d;
      if (cmd_i.load_in) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
      end else if (cmd_i.vscan_init) begin
        scan_idx_q <= '0;
        vfound_q   <= 1'b0;
      end else if (cmd_i.scan_lookup) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        if (cur_match) begin
          found_q <= 1'b1;
        end
      end else if (cmd_i.scan_victim) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        if (cur_better) begin
          vfound_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    val_q  <= val_d;
    cnt_q  <= cnt_d;
    rank_q <= rank_d;
    if (cmd_i.load_in) begin
      is_put_q  <= (opcode_i == OP_PUT);
      req_key_q <= lookup_key_i;
      req_val_q <= write_value_i;
    end
    if (cmd_i.scan_lookup && cur_match) begin
      slot_q      <= scan_idx_q;
      slot_cnt_q  <= cur_cnt;
      slot_rank_q <= cur_rank;
      slot_val_q  <= cur_val;
    end
    if (cmd_i.scan_victim && cur_better) begin
      victim_q <= scan_idx_q;
      vcnt_q   <= cur_cnt;
      vrank_q  <= cur_rank;
    end
    if (cmd_i.load_out) begin
      hit_q   <= found_q;
      rdata_q <= (!is_put_q && found_q) ? slot_val_q : MISS_DATA;
    end
  end

  assign hit_o        = hit_q;
  assign read_value_o = rdata_q;

endmodule
